>>> hw/rtl/paged_texture_page_offset_macros.svh
// assertion macros shared by the rtl
`ifndef PAGED_TEXTURE_PAGE_OFFSET_MACROS_SVH
`define PAGED_TEXTURE_PAGE_OFFSET_MACROS_SVH

// same-cycle implication
`define PTPO_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptpo assertion failed");

// next-cycle implication
`define PTPO_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptpo assertion failed");

`endif

>>> hw/rtl/ptpo_pkg.sv
`default_nettype none

package ptpo_pkg;

  localparam int MAX_LEVELS     = 16;
  localparam int OFFSET_BITS    = 40;
  localparam int EXT_BITS       = 16;
  localparam int BORDER_BITS    = 8;
  localparam int BPP_BITS       = 7;
  localparam int LCOUNT_BITS    = 5;
  localparam int LEVEL_BITS     = 4;
  localparam int PAGE_BITS      = EXT_BITS + 1;
  localparam int STORE_BITS     = EXT_BITS + BORDER_BITS + 1;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = EXT_BITS / DIV_RADIX_BITS;
  localparam int DIV_CNT_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef logic [OFFSET_BITS-1:0]  offset_t;
  typedef logic [EXT_BITS-1:0]     ext_t;
  typedef logic [PAGE_BITS-1:0]    page_t;
  typedef logic [STORE_BITS-1:0]   store_t;
  typedef logic [LEVEL_BITS-1:0]   level_t;
  typedef logic [LCOUNT_BITS-1:0]  lcount_t;
  typedef logic [DIV_CNT_BITS-1:0] divcnt_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_SIZE       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BORDER_SIZE     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BYTES_PER_PIXEL = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_BYTES    = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_COUNT     = 3'd6;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEVEL = 2'd1,
    ST_BAD_COL   = 2'd2,
    ST_BAD_ROW   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MUL_NONE     = 3'd0,
    MUL_SW_SH    = 3'd1,
    MUL_P_BPP    = 3'd2,
    MUL_ROW_SW   = 3'd3,
    MUL_P_FULL   = 3'd4,
    MUL_COL_FULL = 3'd5,
    MUL_P_PH     = 3'd6
  } mul_op_t;

  typedef struct packed {
    ext_t                   image_width;
    ext_t                   image_height;
    ext_t                   tile_size;
    logic [BORDER_BITS-1:0] border_size;
    logic [BPP_BITS-1:0]    bytes_per_pixel;
    ext_t                   header_bytes;
    lcount_t                level_count;
  } cfg_t;

  typedef struct packed {
    logic    load_req;
    logic    div_start;
    logic    div_step;
    logic    ext;
    mul_op_t mul_op;
    logic    acc_en;
    logic    lvl_inc;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic bad_level;
    logic at_level;
    logic bad_page;
    logic res_free;
  } stat_t;

  typedef struct packed {
    ext_t rem;
    ext_t quo;
    ext_t dvd;
  } div_t;

endpackage

`default_nettype wire

>>> hw/rtl/paged_texture_page_offset.sv
// Page offset lookup for a paged, mip-chained texture store.
// Request channel (req_valid/req_ready) carries mip_level, page_col and
// page_row; the result channel (res_valid/res_ready) returns byte_offset,
// page_width, page_height and status (0 ok, 1 bad level, 2 bad column,
// 3 bad row; sizes and offset are zero on error).
// Registers are written over the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data), always ready; the user must write them only while no request is
// in flight, as the block itself does not enforce it.
// One request is worked at a time: each level below the requested one takes
// a radix-16 width/height divide plus stored extent and a level size product
// on one shared 40x25 multiplier. The next request is taken in S_IDLE, the
// state entered when the result is loaded, so a request is not taken before
// the last one is finished.
// A new request is taken while a finished result waits in the output
// register; if the receiver stalls, the next result waits in its final state
// and no further request is taken until the output register frees.
// Synchronous reset loads the default register values and empties the
// result register; no clearing pass is needed.
`default_nettype none

module paged_texture_page_offset (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ptpo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ptpo_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                req_valid,
  output logic                                     req_ready,
  input  wire logic [ptpo_pkg::LEVEL_BITS-1:0]     mip_level,
  input  wire logic [ptpo_pkg::EXT_BITS-1:0]       page_col,
  input  wire logic [ptpo_pkg::EXT_BITS-1:0]       page_row,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output logic [ptpo_pkg::OFFSET_BITS-1:0]         byte_offset,
  output logic [ptpo_pkg::PAGE_BITS-1:0]           page_width,
  output logic [ptpo_pkg::PAGE_BITS-1:0]           page_height,
  output logic [1:0]                               status
);

  ptpo_pkg::cfg_t  regs;
  ptpo_pkg::cmd_t  cmd;
  ptpo_pkg::stat_t stat;

  ptpo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  ptpo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptpo_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .cmd         (cmd),
    .stat        (stat),
    .mip_level   (mip_level),
    .page_col    (page_col),
    .page_row    (page_row),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .byte_offset (byte_offset),
    .page_width  (page_width),
    .page_height (page_height),
    .status      (status)
  );

endmodule

`default_nettype wire

>>> hw/rtl/ptpo_cfg.sv
`default_nettype none

module ptpo_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ptpo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [ptpo_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output ptpo_pkg::cfg_t                            regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.image_width     <= 16'd1024;
      regs.image_height    <= 16'd1024;
      regs.tile_size       <= 16'd256;
      regs.border_size     <= 8'd0;
      regs.bytes_per_pixel <= 7'd4;
      regs.header_bytes    <= 16'd11;
      regs.level_count     <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptpo_pkg::REG_IMAGE_WIDTH:     regs.image_width     <= cfg_data;
        ptpo_pkg::REG_IMAGE_HEIGHT:    regs.image_height    <= cfg_data;
        ptpo_pkg::REG_TILE_SIZE:       regs.tile_size       <= cfg_data;
        ptpo_pkg::REG_BORDER_SIZE:     regs.border_size     <= cfg_data[7:0];
        ptpo_pkg::REG_BYTES_PER_PIXEL: regs.bytes_per_pixel <= cfg_data[6:0];
        ptpo_pkg::REG_HEADER_BYTES:    regs.header_bytes    <= cfg_data;
        ptpo_pkg::REG_LEVEL_COUNT:     regs.level_count     <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ptpo_ctrl.sv
`default_nettype none
`include "paged_texture_page_offset_macros.svh"

module ptpo_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire ptpo_pkg::stat_t stat,
  output ptpo_pkg::cmd_t       cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_START = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_EXT   = 14'b00000000001000,
    S_LEVEL = 14'b00000000010000,
    S_LB1   = 14'b00000000100000,
    S_LB2   = 14'b00000001000000,
    S_F1    = 14'b00000010000000,
    S_F2    = 14'b00000100000000,
    S_F3    = 14'b00001000000000,
    S_F4    = 14'b00010000000000,
    S_F5    = 14'b00100000000000,
    S_F6    = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t            state, state_next;
  ptpo_pkg::divcnt_t cnt, cnt_next;
  logic              div_last;

  assign req_ready = (state == S_IDLE);
  assign div_last  = (cnt == ptpo_pkg::divcnt_t'(ptpo_pkg::DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (stat.bad_level) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          cnt_next      = '0;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = ptpo_pkg::divcnt_t'(cnt + 1'b1);
        if (div_last) begin
          state_next = S_EXT;
        end
      end
      S_EXT: begin
        cmd.ext    = 1'b1;
        state_next = S_LEVEL;
      end
      S_LEVEL: begin
        if (!stat.at_level) begin
          cmd.mul_op = ptpo_pkg::MUL_SW_SH;
          state_next = S_LB1;
        end else if (stat.bad_page) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_op = ptpo_pkg::MUL_ROW_SW;
          state_next = S_F1;
        end
      end
      S_LB1: begin
        cmd.mul_op = ptpo_pkg::MUL_P_BPP;
        state_next = S_LB2;
      end
      S_LB2: begin
        cmd.acc_en  = 1'b1;
        cmd.lvl_inc = 1'b1;
        state_next  = S_START;
      end
      S_F1: begin
        cmd.mul_op = ptpo_pkg::MUL_P_FULL;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.mul_op = ptpo_pkg::MUL_P_BPP;
        state_next = S_F3;
      end
      S_F3: begin
        cmd.acc_en = 1'b1;
        cmd.mul_op = ptpo_pkg::MUL_COL_FULL;
        state_next = S_F4;
      end
      S_F4: begin
        cmd.mul_op = ptpo_pkg::MUL_P_PH;
        state_next = S_F5;
      end
      S_F5: begin
        cmd.mul_op = ptpo_pkg::MUL_P_BPP;
        state_next = S_F6;
      end
      S_F6: begin
        cmd.acc_en = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `PTPO_ASSERT_IMPL(a_res_load_free, cmd.res_load, stat.res_free)
  `PTPO_ASSERT_NEXT(a_accept_start, req_valid && req_ready, state == S_START)
  `PTPO_ASSERT_IMPL(a_ext_after_div, state == S_EXT, $past(state) == S_DIV && $past(div_last))

endmodule

`default_nettype wire

>>> hw/rtl/ptpo_dp.sv
`default_nettype none
`include "paged_texture_page_offset_macros.svh"

module ptpo_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ptpo_pkg::cfg_t                    regs,
  input  wire ptpo_pkg::cmd_t                    cmd,
  output ptpo_pkg::stat_t                        stat,
  input  wire logic [ptpo_pkg::LEVEL_BITS-1:0]   mip_level,
  input  wire logic [ptpo_pkg::EXT_BITS-1:0]     page_col,
  input  wire logic [ptpo_pkg::EXT_BITS-1:0]     page_row,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output logic [ptpo_pkg::OFFSET_BITS-1:0]       byte_offset,
  output logic [ptpo_pkg::PAGE_BITS-1:0]         page_width,
  output logic [ptpo_pkg::PAGE_BITS-1:0]         page_height,
  output logic [1:0]                             status
);

  function automatic ptpo_pkg::div_t div_iter(ptpo_pkg::div_t cur, ptpo_pkg::ext_t den);
    ptpo_pkg::div_t         v;
    logic [ptpo_pkg::EXT_BITS:0] part;
    v = cur;
    for (int k = 0; k < ptpo_pkg::DIV_RADIX_BITS; k++) begin
      part  = {v.rem, v.dvd[ptpo_pkg::EXT_BITS-1]};
      v.dvd = {v.dvd[ptpo_pkg::EXT_BITS-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
        part  = part - {1'b0, den};
        v.quo = {v.quo[ptpo_pkg::EXT_BITS-2:0], 1'b1};
      end else begin
        v.quo = {v.quo[ptpo_pkg::EXT_BITS-2:0], 1'b0};
      end
      v.rem = part[ptpo_pkg::EXT_BITS-1:0];
    end
    return v;
  endfunction

  function automatic ptpo_pkg::store_t stored_ext(ptpo_pkg::ext_t e, ptpo_pkg::ext_t n,
                                                  logic [ptpo_pkg::BORDER_BITS-1:0] b);
    logic [ptpo_pkg::EXT_BITS+ptpo_pkg::BORDER_BITS-1:0] nb;
    nb = n * b;
    return ptpo_pkg::store_t'(e) + {nb, 1'b0};
  endfunction

  ptpo_pkg::level_t  req_lvl, lvl_i;
  ptpo_pkg::ext_t    req_col, req_row;
  ptpo_pkg::div_t    dw, dh;
  ptpo_pkg::ext_t    ncol, nrow;
  ptpo_pkg::store_t  sw, sh;
  ptpo_pkg::page_t   lastw, lasth;
  ptpo_pkg::offset_t prod, acc;

  ptpo_pkg::ext_t    wi, hi, ncol_c, nrow_c, edge_w, edge_h;
  ptpo_pkg::page_t   twob, full, pw, ph;
  ptpo_pkg::lcount_t levels;
  logic              bad_col, bad_row;
  ptpo_pkg::status_t res_status;
  ptpo_pkg::offset_t mul_a;
  ptpo_pkg::store_t  mul_b;
  logic [ptpo_pkg::OFFSET_BITS+ptpo_pkg::STORE_BITS-1:0] mul_full;
  logic              res_err, res_zero;

  assign wi = regs.image_width >> lvl_i;
  assign hi = regs.image_height >> lvl_i;

  // page counts and edge interiors from the divider results
  always_comb begin
    if (regs.tile_size == '0) begin
      ncol_c = '0;
      nrow_c = '0;
    end else begin
      ncol_c = dw.quo + ptpo_pkg::ext_t'(dw.rem != '0);
      nrow_c = dh.quo + ptpo_pkg::ext_t'(dh.rem != '0);
    end
    edge_w = (dw.rem != '0) ? dw.rem : regs.tile_size;
    edge_h = (dh.rem != '0) ? dh.rem : regs.tile_size;
  end

  assign twob = ptpo_pkg::page_t'({regs.border_size, 1'b0});
  assign full = ptpo_pkg::page_t'(regs.tile_size) + twob;
  assign pw   = (req_col == ncol - 1'b1) ? lastw : full;
  assign ph   = (req_row == nrow - 1'b1) ? lasth : full;

  assign levels  = (regs.level_count > ptpo_pkg::lcount_t'(ptpo_pkg::MAX_LEVELS))
                 ? ptpo_pkg::lcount_t'(ptpo_pkg::MAX_LEVELS) : regs.level_count;
  assign bad_col = (req_col >= ncol);
  assign bad_row = (req_row >= nrow);

  always_comb begin
    stat.bad_level = (ptpo_pkg::lcount_t'(req_lvl) >= levels);
    stat.at_level  = (lvl_i == req_lvl);
    stat.bad_page  = bad_col || bad_row;
    stat.res_free  = !res_valid || res_ready;
  end

  always_comb begin
    if (stat.bad_level) begin
      res_status = ptpo_pkg::ST_BAD_LEVEL;
    end else if (bad_col) begin
      res_status = ptpo_pkg::ST_BAD_COL;
    end else if (bad_row) begin
      res_status = ptpo_pkg::ST_BAD_ROW;
    end else begin
      res_status = ptpo_pkg::ST_OK;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      ptpo_pkg::MUL_SW_SH: begin
        mul_a = ptpo_pkg::offset_t'(sw);
        mul_b = sh;
      end
      ptpo_pkg::MUL_P_BPP: begin
        mul_a = prod;
        mul_b = ptpo_pkg::store_t'(regs.bytes_per_pixel);
      end
      ptpo_pkg::MUL_ROW_SW: begin
        mul_a = ptpo_pkg::offset_t'(req_row);
        mul_b = sw;
      end
      ptpo_pkg::MUL_P_FULL: begin
        mul_a = prod;
        mul_b = ptpo_pkg::store_t'(full);
      end
      ptpo_pkg::MUL_COL_FULL: begin
        mul_a = ptpo_pkg::offset_t'(req_col);
        mul_b = ptpo_pkg::store_t'(full);
      end
      ptpo_pkg::MUL_P_PH: begin
        mul_a = prod;
        mul_b = ptpo_pkg::store_t'(ph);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_lvl <= mip_level;
      req_col <= page_col;
      req_row <= page_row;
      lvl_i   <= '0;
      acc     <= ptpo_pkg::offset_t'(regs.header_bytes);
    end else begin
      if (cmd.lvl_inc) begin
        lvl_i <= lvl_i + 1'b1;
      end
      if (cmd.acc_en) begin
        acc <= acc + prod;
      end
    end
    if (cmd.div_start) begin
      dw <= '{rem: '0, quo: '0, dvd: wi};
      dh <= '{rem: '0, quo: '0, dvd: hi};
    end else if (cmd.div_step) begin
      dw <= div_iter(dw, regs.tile_size);
      dh <= div_iter(dh, regs.tile_size);
    end
    if (cmd.ext) begin
      ncol  <= ncol_c;
      nrow  <= nrow_c;
      sw    <= stored_ext(wi, ncol_c, regs.border_size);
      sh    <= stored_ext(hi, nrow_c, regs.border_size);
      lastw <= ptpo_pkg::page_t'(edge_w) + twob;
      lasth <= ptpo_pkg::page_t'(edge_h) + twob;
    end
    if (cmd.mul_op != ptpo_pkg::MUL_NONE) begin
      prod <= mul_full[ptpo_pkg::OFFSET_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status <= res_status;
      if (res_status == ptpo_pkg::ST_OK) begin
        byte_offset <= acc;
        page_width  <= pw;
        page_height <= ph;
      end else begin
        byte_offset <= '0;
        page_width  <= '0;
        page_height <= '0;
      end
    end
  end

  assign res_err  = res_valid && (status != ptpo_pkg::ST_OK);
  assign res_zero = (byte_offset == '0) && (page_width == '0) && (page_height == '0);

  `PTPO_ASSERT_IMPL(a_err_zero, res_err, res_zero)
  `PTPO_ASSERT_NEXT(a_load_valid, cmd.res_load, res_valid)
  `PTPO_ASSERT_IMPL(a_level_bound, cmd.lvl_inc, lvl_i != req_lvl)

endmodule

`default_nettype wire
